@@ sv/csvqs_pkg.sv @@
// Shared types and constants for the CSV quoted field splitter.
package csvqs_pkg;

	localparam int MAX_FIELDS_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] QUOTE_BYTE = 8'h22;
	localparam logic [7:0] COMMA_BYTE = 8'h2C;

	typedef enum logic [2:0] {
		MODE_START,
		MODE_PLAIN,
		MODE_QUOTED,
		MODE_QSEEN,
		MODE_FULL
	} mode_t;

	typedef enum logic [1:0] {
		RK_DATA = 2'd0,
		RK_FEND = 2'd1,
		RK_LEND = 2'd2
	} rk_t;

	typedef struct packed {
		rk_t        kind;
		logic [7:0] data;
		logic [2:0] field;
		logic [3:0] found;
	} res_t;

	// One queue entry holds every result that a single input beat causes.
	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} entry_t;

endpackage

@@ sv/csv_quoted_field_splitter_unit.sv @@
// Top level of the CSV quoted field splitter.
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid / in_stall    kind, line_byte
//   out      source     out_valid / out_stall  result_kind, out_byte, field_number,
//                                              fields_found, last_of_run
//
// One input beat is taken every cycle while the entry queue has room; its entry, if it
// yields any result, is written at the accepting edge and later moved from the queue
// head into the output register. A beat with two results sends two output beats;
// QUEUE_DEPTH entries absorb the difference. in_stall rises only when the queue is
// full. arst_n clears the parse state, the queue pointers and the output valid at
// once; no clearing pass follows.
module csv_quoted_field_splitter_unit #(
	parameter int MAX_FIELDS  = csvqs_pkg::MAX_FIELDS_DEF,
	parameter int QUEUE_DEPTH = csvqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] line_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] result_kind,
	output logic [7:0] out_byte,
	output logic [2:0] field_number,
	output logic [3:0] fields_found,
	output logic       last_of_run
);

	logic              accept, push, pop, empty, full;
	csvqs_pkg::entry_t ent, head;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	csvqs_front #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (kind),
		.line_byte (line_byte),
		.push      (push),
		.ent       (ent)
	);

	csvqs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (ent),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	csvqs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (!empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.out_byte     (out_byte),
		.field_number (field_number),
		.fields_found (fields_found),
		.last_of_run  (last_of_run)
	);

endmodule

@@ sv/csvqs_front.sv @@
// Front end: parse state machine that classifies each input beat into a queue entry.
module csvqs_front #(
	parameter int MAX_FIELDS = csvqs_pkg::MAX_FIELDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              kind,
	input  logic [7:0]        line_byte,
	output logic              push,
	output csvqs_pkg::entry_t ent
);

	localparam int FW = $clog2(MAX_FIELDS + 1);

	csvqs_pkg::mode_t mode_q, mode_d;
	logic [FW-1:0]    field_q, field_d, field_inc;
	logic             close_full;
	logic             is_quote, is_comma, has_res;

	assign field_inc  = field_q + FW'(1);
	assign close_full = (field_inc >= FW'(MAX_FIELDS));
	assign is_quote   = (line_byte == csvqs_pkg::QUOTE_BYTE);
	assign is_comma   = (line_byte == csvqs_pkg::COMMA_BYTE);

	always_comb begin
		mode_d  = mode_q;
		field_d = field_q;
		if (kind) begin
			mode_d  = csvqs_pkg::MODE_START;
			field_d = '0;
		end else begin
			unique case (mode_q)
				csvqs_pkg::MODE_START: begin
					if (is_quote) begin
						mode_d = csvqs_pkg::MODE_QUOTED;
					end else if (is_comma) begin
						field_d = field_inc;
						mode_d  = close_full ? csvqs_pkg::MODE_FULL : csvqs_pkg::MODE_START;
					end else begin
						mode_d = csvqs_pkg::MODE_PLAIN;
					end
				end
				csvqs_pkg::MODE_PLAIN: begin
					if (is_comma) begin
						field_d = field_inc;
						mode_d  = close_full ? csvqs_pkg::MODE_FULL : csvqs_pkg::MODE_START;
					end
				end
				csvqs_pkg::MODE_QUOTED: begin
					if (is_quote) begin
						mode_d = csvqs_pkg::MODE_QSEEN;
					end
				end
				csvqs_pkg::MODE_QSEEN: begin
					if (is_quote) begin
						mode_d = csvqs_pkg::MODE_QUOTED;
					end else begin
						field_d = field_inc;
						if (close_full) begin
							mode_d = csvqs_pkg::MODE_FULL;
						end else if (is_comma) begin
							mode_d = csvqs_pkg::MODE_START;
						end else begin
							mode_d = csvqs_pkg::MODE_PLAIN;
						end
					end
				end
				default: begin
					mode_d = csvqs_pkg::MODE_FULL;
				end
			endcase
		end
	end

	always_comb begin
		ent     = '0;
		has_res = 1'b0;
		if (kind) begin
			has_res = 1'b1;
			if (mode_q != csvqs_pkg::MODE_FULL) begin
				ent.r0.kind  = csvqs_pkg::RK_FEND;
				ent.r0.field = 3'(field_q);
				ent.r1.kind  = csvqs_pkg::RK_LEND;
				ent.r1.found = 4'(field_inc);
				ent.two      = 1'b1;
			end else begin
				ent.r0.kind  = csvqs_pkg::RK_LEND;
				ent.r0.found = 4'(field_q);
			end
		end else begin
			ent.r0.field = 3'(field_q);
			unique case (mode_q)
				csvqs_pkg::MODE_START, csvqs_pkg::MODE_PLAIN: begin
					if (is_comma) begin
						has_res     = 1'b1;
						ent.r0.kind = csvqs_pkg::RK_FEND;
					end else if (!(is_quote && mode_q == csvqs_pkg::MODE_START)) begin
						has_res     = 1'b1;
						ent.r0.kind = csvqs_pkg::RK_DATA;
						ent.r0.data = line_byte;
					end
				end
				csvqs_pkg::MODE_QUOTED: begin
					if (!is_quote) begin
						has_res     = 1'b1;
						ent.r0.kind = csvqs_pkg::RK_DATA;
						ent.r0.data = line_byte;
					end
				end
				csvqs_pkg::MODE_QSEEN: begin
					has_res = 1'b1;
					if (is_quote) begin
						ent.r0.kind = csvqs_pkg::RK_DATA;
						ent.r0.data = csvqs_pkg::QUOTE_BYTE;
					end else begin
						ent.r0.kind = csvqs_pkg::RK_FEND;
						if (!is_comma && !close_full) begin
							ent.two      = 1'b1;
							ent.r1.kind  = csvqs_pkg::RK_DATA;
							ent.r1.data  = line_byte;
							ent.r1.field = 3'(field_inc);
						end
					end
				end
				default: begin
					has_res = 1'b0;
				end
			endcase
		end
	end

	assign push = accept && has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= csvqs_pkg::MODE_START;
			field_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			field_q <= field_d;
		end
	end

	a_full_mode_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == csvqs_pkg::MODE_FULL |-> field_q == FW'(MAX_FIELDS))
		else $error("line full mode without a full field count");

	a_field_bound: assert property (@(posedge clk) disable iff (!arst_n)
		field_q <= FW'(MAX_FIELDS))
		else $error("field index beyond the field limit");

endmodule

@@ sv/csvqs_queue.sv @@
// Short queue of parsed entries between the front and back ends.
module csvqs_queue #(
	parameter int DEPTH = csvqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csvqs_pkg::entry_t push_data,
	input  logic              pop,
	output csvqs_pkg::entry_t head,
	output logic              empty,
	output logic              full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	csvqs_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("entry pushed into a full queue");

endmodule

@@ sv/csvqs_back.sv @@
// Back end: unpacks queue entries into single result beats behind an output register.
module csvqs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  csvqs_pkg::entry_t head,
	input  logic              head_valid,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        result_kind,
	output logic [7:0]        out_byte,
	output logic [2:0]        field_number,
	output logic [3:0]        fields_found,
	output logic              last_of_run
);

	logic            out_valid_q, phase_q, load, last_d;
	csvqs_pkg::res_t sel;
	csvqs_pkg::res_t res_q;
	logic            last_q;

	assign load   = head_valid && (!out_valid_q || !out_stall);
	assign sel    = phase_q ? head.r1 : head.r0;
	assign last_d = phase_q || !head.two;
	assign pop    = load && last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= !last_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= sel;
			last_q <= last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = res_q.kind;
	assign out_byte     = res_q.data;
	assign field_number = res_q.field;
	assign fields_found = res_q.found;
	assign last_of_run  = last_q;

	a_second_half_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> head_valid && head.two)
		else $error("second result pending without its queue entry");

	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == csvqs_pkg::RK_LEND |-> last_q)
		else $error("line end not marked as last of its run");

endmodule

@@ tb/splitter_checker.sv @@
// Checker for the CSV splitter: predicts result beats from input beats and compares them.
`timescale 1ns / 100ps

module splitter_checker
	import csvqs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       line_end,
	input  logic [7:0] line_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] result_kind,
	input  logic [7:0] out_byte,
	input  logic [2:0] field_number,
	input  logic [3:0] fields_found,
	input  logic       last_of_run,
	output int         error_count,
	output int         results_owed
);

	localparam int MAX_FIELDS = MAX_FIELDS_DEF;

	typedef struct packed {
		rk_t        kind;
		logic [7:0] data;
		logic [2:0] field;
		logic [3:0] found;
		logic       last;
	} split_result_t;

	split_result_t expected_results[$];
	split_result_t beat_run[2];
	int            beat_len;
	mode_t         mode;
	logic [3:0]    open_field;

	task automatic add_result(input rk_t k, input logic [7:0] b, input logic [3:0] f,
			input logic [3:0] n);
		beat_run[beat_len] = '{k, b, f[2:0], n, 1'b0};
		beat_len++;
	endtask

	task automatic close_field();
		add_result(RK_FEND, 8'h00, open_field, 4'd0);
		open_field++;
		mode = (open_field >= MAX_FIELDS) ? MODE_FULL : MODE_START;
	endtask

	task automatic split_beat(input logic eol, input logic [7:0] b);
		beat_len = 0;
		if (open_field >= MAX_FIELDS)
			mode = MODE_FULL;
		if (eol) begin
			if (mode != MODE_FULL)
				close_field();
			add_result(RK_LEND, 8'h00, 4'd0, open_field);
			mode = MODE_START;
			open_field = 4'd0;
		end else begin
			case (mode)
				MODE_START: begin
					if (b == QUOTE_BYTE) begin
						mode = MODE_QUOTED;
					end else if (b == COMMA_BYTE) begin
						close_field();
					end else begin
						add_result(RK_DATA, b, open_field, 4'd0);
						mode = MODE_PLAIN;
					end
				end
				MODE_PLAIN: begin
					if (b == COMMA_BYTE)
						close_field();
					else
						add_result(RK_DATA, b, open_field, 4'd0);
				end
				MODE_QUOTED: begin
					if (b == QUOTE_BYTE)
						mode = MODE_QSEEN;
					else
						add_result(RK_DATA, b, open_field, 4'd0);
				end
				MODE_QSEEN: begin
					if (b == QUOTE_BYTE) begin
						add_result(RK_DATA, QUOTE_BYTE, open_field, 4'd0);
						mode = MODE_QUOTED;
					end else if (b == COMMA_BYTE) begin
						close_field();
					end else begin
						close_field();
						if (mode != MODE_FULL) begin
							add_result(RK_DATA, b, open_field, 4'd0);
							mode = MODE_PLAIN;
						end
					end
				end
				default: begin
					mode = MODE_FULL;
				end
			endcase
		end
		for (int i = 0; i < beat_len; i++) begin
			if (i == beat_len - 1)
				beat_run[i].last = 1'b1;
			expected_results.push_back(beat_run[i]);
		end
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	task automatic check_result();
		split_result_t want;
		if (expected_results.size() == 0) begin
			$error("result beat with nothing expected: kind %0h, byte %0h, field %0h",
				result_kind, out_byte, field_number);
			error_count++;
		end else begin
			want = expected_results.pop_front();
			compare_field("result_kind", want.kind, result_kind);
			compare_field("out_byte", want.data, out_byte);
			compare_field("field_number", want.field, field_number);
			compare_field("fields_found", want.found, fields_found);
			compare_field("last_of_run", want.last, last_of_run);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = MODE_START;
			open_field = 4'd0;
			expected_results.delete();
			error_count = 0;
			results_owed = 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				split_beat(line_end, line_byte);
			results_owed = expected_results.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// Testbench top for the CSV splitter: clock, reset, line stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module testbench;
	import csvqs_pkg::*;

	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_EOL     = 1'b1;
	localparam int   RANDOM_BEATS = 1950;
	localparam int   PHASE_BEATS  = 250;
	localparam int   CYCLE_LIMIT  = 400000;
	localparam int   TAIL_CYCLES  = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       kind = KIND_BYTE;
	logic [7:0] line_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] result_kind;
	logic [7:0] out_byte;
	logic [2:0] field_number;
	logic [3:0] fields_found;
	logic       last_of_run;
	int         error_count;
	int         results_owed;
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         beats_sent = 0;
	int         cycle_count = 0;

	csv_quoted_field_splitter_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.line_byte   (line_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.out_byte    (out_byte),
		.field_number(field_number),
		.fields_found(fields_found),
		.last_of_run (last_of_run)
	);

	splitter_checker u_splitter_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.line_end    (kind),
		.line_byte   (line_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.out_byte    (out_byte),
		.field_number(field_number),
		.fields_found(fields_found),
		.last_of_run (last_of_run),
		.error_count (error_count),
		.results_owed(results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic send_beat(input logic k, input logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		line_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		beats_sent++;
	endtask

	task automatic send_line(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(KIND_BYTE, s[i]);
		send_beat(KIND_EOL, 8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] text_byte(input bit allow_quote, input bit allow_comma);
		logic [7:0] b;
		if (allow_quote && $urandom_range(0, 15) == 0)
			return QUOTE_BYTE;
		b = 8'($urandom_range(0, 255));
		if (b == QUOTE_BYTE || (!allow_comma && b == COMMA_BYTE))
			b = 8'h2D;
		return b;
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 3))
			0:       return QUOTE_BYTE;
			1:       return COMMA_BYTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_line();
		int fields;
		int len;
		int shape;
		if ($urandom_range(0, 9) == 0) begin
			len = $urandom_range(0, 24);
			for (int i = 0; i < len; i++)
				send_beat(KIND_BYTE, noise_byte());
		end else begin
			fields = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
			for (int f = 0; f < fields; f++) begin
				shape = $urandom_range(0, 3);
				len = $urandom_range(0, 6);
				if (shape == 0) begin
					for (int i = 0; i < len; i++)
						send_beat(KIND_BYTE, text_byte(i != 0, 1'b0));
				end else begin
					send_beat(KIND_BYTE, QUOTE_BYTE);
					for (int i = 0; i < len; i++) begin
						if ($urandom_range(0, 5) == 0) begin
							send_beat(KIND_BYTE, QUOTE_BYTE);
							send_beat(KIND_BYTE, QUOTE_BYTE);
						end else begin
							send_beat(KIND_BYTE, text_byte(1'b0, 1'b1));
						end
					end
					// An unterminated quote is only left open on the last field of a line.
					if (!(shape == 3 && f == fields - 1))
						send_beat(KIND_BYTE, QUOTE_BYTE);
					if (shape == 2) begin
						len = $urandom_range(1, 3);
						for (int i = 0; i < len; i++)
							send_beat(KIND_BYTE, text_byte(i != 0, 1'b0));
					end
				end
				if (f < fields - 1 || $urandom_range(0, 7) == 0)
					send_beat(KIND_BYTE, COMMA_BYTE);
			end
		end
		send_beat(KIND_EOL, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int start;
		int phase;
		int last_phase;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_pct = 29;
		stall_pct = 29;
		send_beat(KIND_EOL, 8'hFF);
		send_beat(KIND_BYTE, 8'h00);
		send_beat(KIND_BYTE, 8'hFF);
		send_line(",");
		send_line("\"\"\"\"z");
		send_line("\"a");
		send_line("\"\",,,,,,,,\"");
		drain();

		start = beats_sent;
		last_phase = -1;
		while (beats_sent - start < RANDOM_BEATS) begin
			phase = ((beats_sent - start) / PHASE_BEATS) % 4;
			if (phase != last_phase) begin
				drain();
				case (phase)
					0: begin
						idle_pct = 0;
						stall_pct = 0;
					end
					1: begin
						idle_pct = 63;
						stall_pct = 0;
					end
					2: begin
						idle_pct = 0;
						stall_pct = 63;
					end
					default: begin
						idle_pct = 29;
						stall_pct = 29;
					end
				endcase
				last_phase = phase;
			end
			send_random_line();
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
